// ----- sv/ura_pkg.sv -----
package ura_pkg;

    localparam int COUNT_WIDTH = 16;
    localparam int DIST_W      = 11;
    localparam int TRIG_W      = 10;
    localparam int MAX_ECHO_W  = 16;
    localparam int LIMIT_W     = 10;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 16;

    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;

    // ticks / 58 as (ticks * ceil(2^22 / 58)) >> 22, exact for ticks below 174762
    localparam int                      CM_RECIP_W = 17;
    localparam logic [CM_RECIP_W-1:0]   CM_RECIP   = 17'd72316;
    localparam int                      CM_SHIFT   = 22;
    localparam int                      CM_PROD_W  = COUNT_WIDTH + CM_RECIP_W;

    localparam logic [TRIG_W-1:0]     TRIG_RESET     = 10'd10;
    localparam logic [MAX_ECHO_W-1:0] MAX_ECHO_RESET = 16'd23200;
    localparam logic [LIMIT_W-1:0]    NEAR_RESET     = 10'd50;
    localparam logic [LIMIT_W-1:0]    DANGER_RESET   = 10'd30;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_TRIG,
        PH_WAIT,
        PH_COUNT
    } t_phase;

    typedef enum logic [1:0] {
        ZONE_NONE,
        ZONE_FAR,
        ZONE_SHORT,
        ZONE_DANGER
    } t_zone;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TRIGGER_TICKS,
        CFG_MAX_ECHO_TICKS,
        CFG_NEAR_LIMIT_CM,
        CFG_DANGER_LIMIT_CM
    } t_cfg_idx;

    typedef struct packed {
        logic [TRIG_W-1:0]     trigger_ticks;
        logic [MAX_ECHO_W-1:0] max_echo_ticks;
        logic [LIMIT_W-1:0]    near_limit_cm;
        logic [LIMIT_W-1:0]    danger_limit_cm;
    } t_cfg;

    typedef struct packed {
        logic echo_level;
        logic start_request;
    } t_tick;

    typedef struct packed {
        logic  valid;
        t_tick item;
    } t_tick_stage;

    typedef struct packed {
        logic              trigger_out;
        logic              measure_done;
        logic [DIST_W-1:0] distance_cm;
        logic [1:0]        zone;
        logic              led_red;
        logic              lamp_green;
        logic              buzzer;
        logic              busy_res;
    } t_result;

    function automatic logic [DIST_W-1:0] ticks_to_cm(input logic [COUNT_WIDTH-1:0] ticks);
        logic [CM_PROD_W-1:0] prod;
        prod = CM_PROD_W'(ticks) * CM_PROD_W'(CM_RECIP);
        return prod[CM_SHIFT +: DIST_W];
    endfunction

endpackage

// ----- sv/ura_tick_if.sv -----
interface ura_tick_if;
    logic valid;
    logic ready;
    logic echo_level;
    logic start_request;

    modport source (output valid, output echo_level, output start_request, input ready);
    modport sink   (input valid, input echo_level, input start_request, output ready);
endinterface

// ----- sv/ura_result_if.sv -----
interface ura_result_if;
    import ura_pkg::*;

    logic              valid;
    logic              ready;
    logic              trigger_out;
    logic              measure_done;
    logic [DIST_W-1:0] distance_cm;
    logic [1:0]        zone;
    logic              led_red;
    logic              lamp_green;
    logic              buzzer;
    logic              busy_res;

    modport source (
        output valid, output trigger_out, output measure_done, output distance_cm,
        output zone, output led_red, output lamp_green, output buzzer, output busy_res,
        input ready
    );
    modport sink (
        input valid, input trigger_out, input measure_done, input distance_cm,
        input zone, input led_red, input lamp_green, input buzzer, input busy_res,
        output ready
    );
endinterface

// ----- sv/ura_cfg_regs.sv -----
module ura_cfg_regs (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_wr_en,
    input  logic [ura_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [ura_pkg::CFG_DATA_W-1:0] i_cfg_wdata,
    output ura_pkg::t_cfg             o_cfg
);
    import ura_pkg::*;

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.trigger_ticks   <= TRIG_RESET;
            r_cfg.max_echo_ticks  <= MAX_ECHO_RESET;
            r_cfg.near_limit_cm   <= NEAR_RESET;
            r_cfg.danger_limit_cm <= DANGER_RESET;
        end else if (i_cfg_wr_en) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_TRIGGER_TICKS:   r_cfg.trigger_ticks   <= i_cfg_wdata[TRIG_W-1:0];
                CFG_MAX_ECHO_TICKS:  r_cfg.max_echo_ticks  <= i_cfg_wdata[MAX_ECHO_W-1:0];
                CFG_NEAR_LIMIT_CM:   r_cfg.near_limit_cm   <= i_cfg_wdata[LIMIT_W-1:0];
                CFG_DANGER_LIMIT_CM: r_cfg.danger_limit_cm <= i_cfg_wdata[LIMIT_W-1:0];
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;
endmodule

// ----- sv/ura_in_stage.sv -----
module ura_in_stage (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    ura_tick_if.sink             i_tick,
    input  logic                 i_take,
    output ura_pkg::t_tick_stage o_stage
);
    import ura_pkg::*;

    logic  r_valid;
    t_tick r_item;
    logic  accept;

    assign i_tick.ready = !r_valid || i_take;
    assign accept       = i_tick.valid && i_tick.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (accept) begin
            r_valid <= 1'b1;
        end else if (i_take) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_item.echo_level    <= i_tick.echo_level;
            r_item.start_request <= i_tick.start_request;
        end
    end

    assign o_stage.valid = r_valid;
    assign o_stage.item  = r_item;
endmodule

// ----- sv/ura_core.sv -----
module ura_core (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  ura_pkg::t_cfg        i_cfg,
    input  ura_pkg::t_tick_stage i_stage,
    input  logic                 i_advance,
    output ura_pkg::t_result     o_result
);
    import ura_pkg::*;

    t_phase                 r_phase, n_phase;
    logic [COUNT_WIDTH-1:0] r_count, n_count;
    logic [DIST_W-1:0]      r_dist, n_dist;
    t_zone                  r_zone, n_zone;

    logic                   trig;
    logic                   done;
    logic [COUNT_WIDTH-1:0] trig_len;
    logic [COUNT_WIDTH-1:0] count_inc;
    logic [DIST_W-1:0]      meas_cm;
    logic                   echo;
    logic                   start;

    assign echo      = i_stage.item.echo_level;
    assign start     = i_stage.item.start_request;
    assign trig_len  = COUNT_WIDTH'(i_cfg.trigger_ticks);
    assign count_inc = r_count + COUNT_WIDTH'(1);
    // echo longer than the accepted maximum reads as zero distance
    assign meas_cm   = (r_count <= COUNT_WIDTH'(i_cfg.max_echo_ticks))
                       ? ticks_to_cm(r_count) : '0;

    // next state
    always_comb begin
        n_phase = r_phase;
        n_count = r_count;
        unique case (r_phase)
            PH_IDLE: begin
                if (start) begin
                    if (trig_len <= COUNT_WIDTH'(1)) begin
                        n_phase = PH_WAIT;
                        n_count = '0;
                    end else begin
                        n_phase = PH_TRIG;
                        n_count = COUNT_WIDTH'(1);
                    end
                end
            end
            PH_TRIG: begin
                n_count = count_inc;
                if (count_inc >= trig_len) begin
                    n_phase = PH_WAIT;
                    n_count = '0;
                end
            end
            PH_WAIT: begin
                if (echo) begin
                    n_phase = PH_COUNT;
                    n_count = COUNT_WIDTH'(1);
                end
            end
            PH_COUNT: begin
                if (echo) begin
                    if (r_count != COUNT_MAX) begin
                        n_count = count_inc;
                    end
                end else begin
                    n_phase = PH_IDLE;
                    n_count = '0;
                end
            end
            default: ;
        endcase
    end

    // outputs and held measurement
    always_comb begin
        trig   = (r_phase == PH_TRIG) || (r_phase == PH_IDLE && start);
        done   = (r_phase == PH_COUNT) && !echo;
        n_dist = r_dist;
        n_zone = r_zone;
        if (done) begin
            n_dist = meas_cm;
            priority if (meas_cm > DIST_W'(i_cfg.near_limit_cm)) begin
                n_zone = ZONE_FAR;
            end else if (meas_cm < DIST_W'(i_cfg.danger_limit_cm)) begin
                n_zone = ZONE_DANGER;
            end else begin
                n_zone = ZONE_SHORT;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_count <= '0;
            r_dist  <= '0;
            r_zone  <= ZONE_NONE;
        end else if (i_advance) begin
            r_phase <= n_phase;
            r_count <= n_count;
            r_dist  <= n_dist;
            r_zone  <= n_zone;
        end
    end

    assign o_result.trigger_out  = trig;
    assign o_result.measure_done = done;
    assign o_result.distance_cm  = n_dist;
    assign o_result.zone         = n_zone;
    assign o_result.led_red      = (n_zone == ZONE_SHORT) || (n_zone == ZONE_DANGER);
    assign o_result.lamp_green   = (n_zone == ZONE_FAR);
    assign o_result.buzzer       = (n_zone == ZONE_DANGER);
    assign o_result.busy_res     = (n_phase != PH_IDLE);
endmodule

// ----- sv/ura_out_stage.sv -----
module ura_out_stage (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_load,
    input  ura_pkg::t_result i_result,
    output logic             o_free,
    ura_result_if.source     o_res
);
    import ura_pkg::*;

    logic    r_valid;
    t_result r_result;

    assign o_free = !r_valid || o_res.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_result <= i_result;
        end
    end

    assign o_res.valid        = r_valid;
    assign o_res.trigger_out  = r_result.trigger_out;
    assign o_res.measure_done = r_result.measure_done;
    assign o_res.distance_cm  = r_result.distance_cm;
    assign o_res.zone         = r_result.zone;
    assign o_res.led_red      = r_result.led_red;
    assign o_res.lamp_green   = r_result.lamp_green;
    assign o_res.buzzer       = r_result.buzzer;
    assign o_res.busy_res     = r_result.busy_res;
endmodule

// ----- sv/ultrasonic_range_alarm.sv -----
// Path: an item accepted into the input register then moves into the result register,
//   from which it can leave; one reciprocal multiply sits between the two registers.
// Throughput: one item per cycle, sustained while the result side takes every cycle.
// Reset: synchronous, active low; clears phase, tick count, held distance and zone,
//   both stage valids, and loads the configuration registers with their defaults.
module ultrasonic_range_alarm (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    ura_tick_if.sink                       i_tick,
    ura_result_if.source                   o_result,
    input  logic                           i_cfg_wr_en,
    input  logic [ura_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [ura_pkg::CFG_DATA_W-1:0] i_cfg_wdata
);
    import ura_pkg::*;

    t_cfg        cfg;
    t_tick_stage stage;
    t_result     result;
    logic        out_free;
    logic        advance;

    assign advance = stage.valid && out_free;

    ura_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata),
        .o_cfg       (cfg)
    );

    ura_in_stage u_in (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_tick  (i_tick),
        .i_take  (advance),
        .o_stage (stage)
    );

    ura_core u_core (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (cfg),
        .i_stage   (stage),
        .i_advance (advance),
        .o_result  (result)
    );

    ura_out_stage u_out (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (advance),
        .i_result (result),
        .o_free   (out_free),
        .o_res    (o_result)
    );

    // a finished measurement always leaves the block idle
    a_done_not_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result.valid && o_result.measure_done) |-> !o_result.busy_res)
        else $error("measure_done with busy_res set");

    // trigger and completion belong to different phases
    a_trig_done_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result.valid |-> !(o_result.trigger_out && o_result.measure_done))
        else $error("trigger_out and measure_done together");

    // an advance always loads the result register, which then holds a valid item
    a_advance_needs_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance |=> o_result.valid)
        else $error("result register not loaded after advance");

    // buzzer and green lamp follow the held zone
    a_lamps_match_zone: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result.valid |-> ((o_result.buzzer == (o_result.zone == ZONE_DANGER))
                           && (o_result.lamp_green == (o_result.zone == ZONE_FAR))))
        else $error("lamp outputs disagree with zone");
endmodule
